// ===== sv/descriptor_slot_allocator_macros.svh =====
// assertion macros for the descriptor slot allocator
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define DSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/dsa_pkg.sv =====
// shared types and constants of the descriptor slot allocator
`default_nettype none
package dsa_pkg;

  localparam int DEF_MAX_SLOTS = 1024;
  localparam int SLOT_W        = 10;
  localparam int OP_W          = 2;
  localparam int POOL_W        = 11;
  localparam int STRIDE_W      = 16;
  localparam int ADDR_W        = 64;
  localparam int PROD_W        = SLOT_W + STRIDE_W;
  localparam int CFG_DW        = 64;
  localparam int CFG_AW        = 5;
  localparam int CMDQ_DEPTH    = 2;
  localparam int RESQ_DEPTH    = 2;

  localparam logic [POOL_W-1:0]   POOL_RST   = POOL_W'(1024);
  localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(32);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REINIT  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC   = 2'd0,
    K_RELEASE = 2'd1,
    K_REINIT  = 2'd2,
    K_NOP     = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    REG_POOL_SIZE = 2'd0,
    REG_STRIDE    = 2'd1,
    REG_CPU_BASE  = 2'd2,
    REG_GPU_BASE  = 2'd3
  } reg_sel_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_PROD = 2'd1,
    BK_SUM  = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot_in;
  } dsa_req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_out;
    logic [ADDR_W-1:0] cpu_address;
    logic [ADDR_W-1:0] gpu_address;
  } dsa_result_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    logic              out_of_range;
  } dsa_cmd_t;

  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   cpu_base;
    logic [ADDR_W-1:0]   gpu_base;
  } dsa_cfg_t;

endpackage
`default_nettype wire

// ===== sv/dsa_fifo.sv =====
// small register queue used between the allocator stages
`default_nettype none
module dsa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dsa_front.sv =====
// request decode and range classification
`default_nettype none
module dsa_front import dsa_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  localparam int CNT_W = $clog2(MAX_SLOTS + 1)
) (
  input  wire dsa_req_t          req,
  input  wire logic [POOL_W-1:0] pool_size,
  output logic      [CNT_W-1:0]  eff_size,
  output dsa_cmd_t               cmd
);

  localparam int SZ_W  = (CNT_W > POOL_W) ? CNT_W : POOL_W;
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  // oversized pool clamps to the built depth
  always_comb begin
    if (SZ_W'(pool_size) > SZ_W'(MAX_SLOTS)) begin
      eff_size = CNT_W'(MAX_SLOTS);
    end else begin
      eff_size = CNT_W'(pool_size);
    end
  end

  always_comb begin
    cmd.slot         = req.slot_in;
    cmd.out_of_range = (CMP_W'(req.slot_in) >= CMP_W'(eff_size));
    unique case (req.op)
      OP_ALLOC:   cmd.kind = K_ALLOC;
      OP_RELEASE: cmd.kind = K_RELEASE;
      OP_REINIT:  cmd.kind = K_REINIT;
      default:    cmd.kind = K_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/dsa_back.sv =====
// release stack, fresh counter and address generation
`default_nettype none
`include "descriptor_slot_allocator_macros.svh"
module dsa_back import dsa_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  localparam int CNT_W = $clog2(MAX_SLOTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_empty,
  input  wire dsa_cmd_t         cmd,
  output logic                  cmd_pop,
  input  wire logic [CNT_W-1:0] eff_size,
  input  wire dsa_cfg_t         cfg,
  input  wire logic             res_full,
  output logic                  res_push,
  output dsa_result_t           res
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              use_mem_r, use_mem_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SLOT_W-1:0] rd_data_r;
  logic [SLOT_W-1:0] stack_mem [MAX_SLOTS];
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [SLOT_W-1:0] op_slot;

  assign rd_addr = AW'(count_r - 1'b1);
  assign wr_addr = AW'(count_r);
  assign op_slot = use_mem_r ? rd_data_r : slot_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    fresh_nxt   = fresh_r;
    slot_nxt    = slot_r;
    use_mem_nxt = use_mem_r;
    prod_nxt    = prod_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    res         = '0;
    res.status  = ST_OK;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            K_ALLOC: begin
              if (count_r != '0) begin
                count_nxt   = CNT_W'(count_r - 1'b1);
                rd_en       = 1'b1;
                use_mem_nxt = 1'b1;
                state_nxt   = BK_PROD;
              end else if (fresh_r < eff_size) begin
                slot_nxt    = SLOT_W'(fresh_r);
                fresh_nxt   = CNT_W'(fresh_r + 1'b1);
                use_mem_nxt = 1'b0;
                state_nxt   = BK_PROD;
              end else begin
                res_push   = 1'b1;
                res.status = ST_EMPTY;
              end
            end
            K_RELEASE: begin
              res_push = 1'b1;
              if (cmd.out_of_range) begin
                res.status = ST_RANGE;
              end else if (count_r == CNT_W'(MAX_SLOTS)) begin
                res.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = CNT_W'(count_r + 1'b1);
              end
            end
            K_REINIT: begin
              res_push  = 1'b1;
              count_nxt = '0;
              fresh_nxt = '0;
            end
            K_NOP: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      BK_PROD: begin
        slot_nxt  = op_slot;
        prod_nxt  = PROD_W'(op_slot) * PROD_W'(cfg.stride);
        state_nxt = BK_SUM;
      end
      BK_SUM: begin
        res_push        = 1'b1;
        res.slot_out    = slot_r;
        res.cpu_address = cfg.cpu_base + ADDR_W'(prod_r);
        res.gpu_address = cfg.gpu_base + ADDR_W'(prod_r);
        state_nxt       = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= '0;
      fresh_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    use_mem_r <= use_mem_nxt;
    prod_r    <= prod_nxt;
  end

  // release stack, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= cmd.slot;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  `DSA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_SLOTS), "stack count beyond depth")
  `DSA_ASSERT_IMP(a_push_room, clk, rst_n, res_push, !res_full, "result pushed into full queue")
  `DSA_ASSERT_NXT(a_prod_to_sum, clk, rst_n, state_r == BK_PROD, state_r == BK_SUM, "product stage not followed by sum")
  `DSA_ASSERT_NXT(a_pop_on_read, clk, rst_n, rd_en, count_r == $past(count_r) - 1'b1, "stack read without pop")

endmodule
`default_nettype wire

// ===== sv/descriptor_slot_allocator.sv =====
// top level: lifo descriptor slot allocator with apb-style register port
// a request waits in the command queue until the back end is free and
//   the result queue has room; release, reinit and empty-pool results
//   are pushed as it is popped; a granted allocate first passes idle (stack
//   read), prod (stride multiply), sum (base add); 2-entry queue on each side
// reset: rst_n synchronous active low; pool empty of released slots, fresh
//   counter at 0, pool_size 1024, stride 32, both bases 0
`default_nettype none
module descriptor_slot_allocator import dsa_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request queue side
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire dsa_req_t          in_req,
  // result queue side
  output logic                   out_empty,
  input  wire logic              out_pop,
  output dsa_result_t            out_result,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  // configuration registers
  logic [POOL_W-1:0]   pool_size_r, pool_size_nxt;
  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  logic [ADDR_W-1:0]   cpu_base_r, cpu_base_nxt;
  logic [ADDR_W-1:0]   gpu_base_r, gpu_base_nxt;
  logic                cfg_wr;
  reg_sel_t            reg_sel;

  // front to back
  dsa_cmd_t         front_cmd;
  dsa_cmd_t         back_cmd;
  logic             cmdq_empty;
  logic             cmd_pop;
  logic [CNT_W-1:0] eff_size;
  dsa_cfg_t         cfg;

  // back to result queue
  logic        res_push;
  logic        resq_full;
  dsa_result_t back_res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // registers sit 8 bytes apart, low address bits ignored
  assign reg_sel = reg_sel_t'(paddr[4:3]);

  always_comb begin
    pool_size_nxt = pool_size_r;
    stride_nxt    = stride_r;
    cpu_base_nxt  = cpu_base_r;
    gpu_base_nxt  = gpu_base_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_POOL_SIZE: pool_size_nxt = pwdata[POOL_W-1:0];
        REG_STRIDE:    stride_nxt    = pwdata[STRIDE_W-1:0];
        REG_CPU_BASE:  cpu_base_nxt  = pwdata;
        REG_GPU_BASE:  gpu_base_nxt  = pwdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_RST;
      stride_r    <= STRIDE_RST;
      cpu_base_r  <= '0;
      gpu_base_r  <= '0;
    end else begin
      pool_size_r <= pool_size_nxt;
      stride_r    <= stride_nxt;
      cpu_base_r  <= cpu_base_nxt;
      gpu_base_r  <= gpu_base_nxt;
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_POOL_SIZE: prdata = CFG_DW'(pool_size_r);
      REG_STRIDE:    prdata = CFG_DW'(stride_r);
      REG_CPU_BASE:  prdata = cpu_base_r;
      REG_GPU_BASE:  prdata = gpu_base_r;
    endcase
  end

  assign cfg.stride   = stride_r;
  assign cfg.cpu_base = cpu_base_r;
  assign cfg.gpu_base = gpu_base_r;

  // front end: decode op and check the release index against the pool size
  dsa_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .req       (in_req),
    .pool_size (pool_size_r),
    .eff_size  (eff_size),
    .cmd       (front_cmd)
  );

  // classified requests wait here until the back end is free
  dsa_fifo #(
    .WIDTH ($bits(dsa_cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (back_cmd),
    .empty (cmdq_empty)
  );

  // back end: stack, fresh counter, multiply and add
  dsa_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmdq_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .eff_size  (eff_size),
    .cfg       (cfg),
    .res_full  (resq_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // finished results wait here for the consumer
  dsa_fifo #(
    .WIDTH ($bits(dsa_result_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (back_res),
    .full  (resq_full),
    .pop   (out_pop),
    .dout  (out_result),
    .empty (out_empty)
  );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the descriptor slot allocator: self-checking, queue-fed driver and monitor
`timescale 1ns / 1ps
module tb;
  import dsa_pkg::*;

  // op code the block treats as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // pause after the last result before a register write
  localparam int DRAIN_CYCLES = 8;
  // receiver hold-off pattern: periodic pauses in popping, set by HOLD_PERIOD and HOLD_LEN
  localparam int HOLD_PERIOD = 700;
  localparam int HOLD_LEN = 60;
  localparam int MAX_REPORTS = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_push = 1'b0;
  logic in_full;
  dsa_req_t in_req = '0;

  logic out_empty;
  logic out_pop = 1'b0;
  dsa_result_t out_result;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  descriptor_slot_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // requests waiting to be offered, and results the allocator still owes us
  dsa_req_t pending_reqs[$];
  dsa_result_t expected_results[$];

  // mirror of the allocator: register copies and free-list state
  logic [POOL_W-1:0] cfg_pool_size = POOL_RST;
  logic [STRIDE_W-1:0] cfg_stride = STRIDE_RST;
  logic [ADDR_W-1:0] cfg_cpu_base = '0;
  logic [ADDR_W-1:0] cfg_gpu_base = '0;
  logic [SLOT_W-1:0] free_stack [DEF_MAX_SLOTS];
  int unsigned free_count = 0;
  int unsigned fresh_next = 0;

  int mismatch_count = 0;
  logic stim_go = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_cycle = 0;

  // pool size as the allocator sees it: anything above the build depth is clamped
  function automatic int unsigned usable_slots();
    return (cfg_pool_size > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : cfg_pool_size;
  endfunction

  // applies one request to the mirror and returns the result it must produce
  function automatic dsa_result_t predict_slot_result(dsa_req_t r);
    dsa_result_t res;
    logic [SLOT_W-1:0] slot;
    logic granted;
    res = '0;
    res.status = ST_OK;
    slot = '0;
    granted = 1'b0;
    case (r.op)
      OP_ALLOC: begin
        // lifo: recently released slots win over never-used ones
        if (free_count > 0) begin
          free_count--;
          slot = free_stack[free_count];
          granted = 1'b1;
        end else if (fresh_next < usable_slots()) begin
          slot = SLOT_W'(fresh_next);
          fresh_next++;
          granted = 1'b1;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      OP_RELEASE: begin
        // a double release is not caught, the slot is simply pushed again
        if (r.slot_in >= usable_slots()) begin
          res.status = ST_RANGE;
        end else if (free_count >= DEF_MAX_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          free_stack[free_count] = r.slot_in;
          free_count++;
        end
      end
      OP_REINIT: begin
        free_count = 0;
        fresh_next = 0;
      end
      default: ;
    endcase
    if (granted) begin
      // addresses wrap modulo 2^64
      res.slot_out = slot;
      res.cpu_address = cfg_cpu_base + ADDR_W'(slot) * ADDR_W'(cfg_stride);
      res.gpu_address = cfg_gpu_base + ADDR_W'(slot) * ADDR_W'(cfg_stride);
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  function automatic void add_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot);
    dsa_req_t r;
    r.op = op;
    r.slot_in = slot;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // sender: bursts of random length with random gaps, changes at the falling edge
  always @(negedge clk) begin
    if (!stim_go || pending_reqs.size() == 0) begin
      in_push <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      in_push <= 1'b0;
    end else begin
      in_push <= 1'b1;
      in_req <= pending_reqs[0];
      if (burst_left <= 1) begin
        // now and then a long burst with no idling at all
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 16);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
  end

  // request accepted: run it through the mirror and queue what should come back
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      expected_results.insert(expected_results.size(), predict_slot_result(in_req));
      void'(pending_reqs.pop_front());
    end
  end

  // receiver: periodic long hold-off so the block backs up and stalls its input,
  // full-rate windows, and random stalls in between
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      rx_cycle++;
      if ((rx_cycle % HOLD_PERIOD) < HOLD_LEN)
        out_pop <= 1'b0;
      else if (((rx_cycle / 97) % 3) == 0)
        out_pop <= 1'b1;
      else
        out_pop <= ($urandom_range(0, 9) < 6);
    end
  end

  // monitor: every popped result is checked against the oldest expectation
  always @(posedge clk) begin : check_results
    dsa_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t ns: result with nothing expected, expected none, got %h",
                   $time, out_result);
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, out_result.status);
        check_field("slot_out", want.slot_out, out_result.slot_out);
        check_field("cpu_address", want.cpu_address, out_result.cpu_address);
        check_field("gpu_address", want.gpu_address, out_result.gpu_address);
      end
    end
  end

  // register write: setup cycle, then access cycle; the mirror follows at the write edge
  task automatic write_reg(input reg_sel_t sel, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      REG_POOL_SIZE: cfg_pool_size = value[POOL_W-1:0];
      REG_STRIDE:    cfg_stride = value[STRIDE_W-1:0];
      REG_CPU_BASE:  cfg_cpu_base = value;
      REG_GPU_BASE:  cfg_gpu_base = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [POOL_W-1:0] pool, input logic [STRIDE_W-1:0] stride,
                            input logic [ADDR_W-1:0] cpu, input logic [ADDR_W-1:0] gpu);
    write_reg(REG_POOL_SIZE, CFG_DW'(pool));
    write_reg(REG_STRIDE, CFG_DW'(stride));
    write_reg(REG_CPU_BASE, cpu);
    write_reg(REG_GPU_BASE, gpu);
  endtask

  // block is idle once every request is in and every result is out
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : run_test
    int unsigned pick;
    int unsigned lim;
    logic [SLOT_W-1:0] slot;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    stim_go <= 1'b1;

    // reset values: fresh slots in order, lifo reuse, double release, unused op, reinit
    add_request(OP_ALLOC, '0);
    add_request(OP_ALLOC, '1);
    add_request(OP_ALLOC, '0);
    add_request(OP_RELEASE, 10'd1);
    add_request(OP_RELEASE, 10'd2);
    add_request(OP_ALLOC, '0);
    add_request(OP_ALLOC, '0);
    add_request(OP_RELEASE, 10'd1023);
    add_request(OP_RELEASE, 10'd1023);
    add_request(OP_ALLOC, '0);
    add_request(OP_ALLOC, '0);
    add_request(OP_UNUSED, 10'd1023);
    add_request(OP_REINIT, 10'd1023);
    add_request(OP_ALLOC, '0);
    wait_drained();

    // oversized pool is clamped; widest stride and all-ones base make the address wrap
    set_config('1, '1, '1, 64'h8000_0000_0000_0000);
    add_request(OP_RELEASE, 10'd1023);
    add_request(OP_ALLOC, '0);
    add_request(OP_ALLOC, '0);
    add_request(OP_RELEASE, 10'd900);
    wait_drained();

    // zero pool: nothing in range, but a slot left on the stack is still handed out
    set_config('0, 16'd1, 64'h0000_0000_1000_0000, '0);
    add_request(OP_RELEASE, 10'd0);
    add_request(OP_ALLOC, '0);
    add_request(OP_ALLOC, '0);
    wait_drained();

    // shrunken pool: fresh slots only below the new size, then empty
    set_config(11'd4, 16'd64, 64'h1000, 64'h2000);
    add_request(OP_RELEASE, 10'd3);
    add_request(OP_RELEASE, 10'd4);
    add_request(OP_ALLOC, '0);
    add_request(OP_ALLOC, '0);
    add_request(OP_ALLOC, '0);
    add_request(OP_ALLOC, '0);
    wait_drained();

    // fill the release stack to the build depth, overflow it, then drain a few lifo
    set_config(11'd1024, 16'($urandom_range(1, 65535)), {$urandom, $urandom},
               {$urandom, $urandom});
    add_request(OP_REINIT, 10'($urandom_range(0, 1023)));
    for (int i = 0; i < DEF_MAX_SLOTS; i++) begin
      if ($urandom_range(0, 15) == 0)
        add_request(OP_UNUSED, 10'($urandom_range(0, 1023)));
      add_request(OP_RELEASE, 10'($urandom_range(0, 1023)));
    end
    for (int i = 0; i < 4; i++)
      add_request(OP_RELEASE, 10'($urandom_range(0, 1023)));
    for (int i = 0; i < 12; i++)
      add_request(OP_ALLOC, 10'($urandom_range(0, 1023)));
    add_request(OP_RELEASE, 10'($urandom_range(0, 1023)));
    wait_drained();

    // random mix under several register settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(11'($urandom_range(1, 16)), 16'($urandom_range(1, 65535)),
                      {$urandom, $urandom}, {$urandom, $urandom});
        1: set_config(11'd1, 16'd1, '0, '1);
        2: set_config(11'd1024, '1, '1, '1);
        3: set_config('1, 16'($urandom_range(1, 65535)), {$urandom, $urandom}, '0);
        4: set_config('0, 16'($urandom_range(1, 65535)), {$urandom, $urandom},
                      {$urandom, $urandom});
        default: set_config(11'($urandom_range(1, 1024)), 16'($urandom_range(1, 65535)),
                            {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      lim = usable_slots();
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 99);
        slot = 10'($urandom_range(0, 1023));
        if (pick < 45) begin
          add_request(OP_ALLOC, slot);
        end else if (pick < 85) begin
          // mostly in-range releases so the stack stays busy, some out of range
          if (lim > 0 && pick < 80)
            slot = 10'($urandom_range(0, lim - 1));
          add_request(OP_RELEASE, slot);
        end else if (pick < 93) begin
          add_request(OP_REINIT, slot);
        end else begin
          add_request(OP_UNUSED, slot);
        end
      end
      wait_drained();
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, many times the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== descriptor_slot_allocator.f =====
+incdir+sv
sv/dsa_pkg.sv
sv/dsa_fifo.sv
sv/dsa_front.sv
sv/dsa_back.sv
sv/descriptor_slot_allocator.sv
verif/tb.sv
